[design/brbs_pkg.sv]
// Shared types and constants of the buddy region block splitter.
package brbs_pkg;

  localparam int FIELD_W      = 32;
  localparam int CEIL_W       = 33;
  localparam int ORDER_W      = 5;
  localparam int APB_DATA_W   = 64;
  localparam int APB_ADDR_W   = 4;
  localparam int REG_SEL_BIT  = 3;
  localparam int RESULT_LIMIT = 40;
  localparam int COUNT_W      = 6;

  localparam logic [CEIL_W-1:0] CEIL_RESET = 33'h1_0000_0000;

  typedef enum logic {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic align;
    logic clip;
    logic span;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;
    logic nonempty;
    logic last;
  } status_t;

endpackage

[design/buddy_region_block_splitter_unit.sv]
// Buddy region block splitter: turns memory map entries into aligned buddy blocks.
//
// The input channel (region_valid/region_ready) takes one memory map entry per
// word. The output channel (block_valid/block_ready) delivers one buddy block per
// word: its address, its order and a mark on the final block of the entry.
// The APB-style port holds the floor and ceiling addresses at byte offsets 0
// and 8 with 64-bit data; pready is always high.
//
// After an entry is accepted, the setup steps round the base, trim the length,
// clip the region and take the span; blocks then follow at one per cycle while
// the receiver keeps up, set by the single order-selection step that produces
// each block from the current address and remaining span. An entry yields at
// most 40 blocks, and the next entry is taken in the cycle after its last block
// is loaded. Entries that yield no block end after the align or the span step.
//
// The output register holds a block while the receiver stalls; emission pauses
// until it is taken, and a new entry may be accepted while the final block
// still waits. Reset clears the handshake state and the past-ceiling flag and
// restores the floor to zero and the ceiling to 4 GiB.
module buddy_region_block_splitter_unit
  import brbs_pkg::*;
#(
  parameter int MAX_ORDER    = 18,
  parameter int ADDRESS_BITS = 32,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  region_valid,
  output logic                  region_ready,
  input  logic [FIELD_W-1:0]    region_base,
  input  logic [FIELD_W-1:0]    region_length,
  input  logic                  region_usable,
  input  logic                  last_entry,
  output logic                  block_valid,
  input  logic                  block_ready,
  output logic [FIELD_W-1:0]    block_address,
  output logic [ORDER_W-1:0]    block_order,
  output logic                  last_block,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Internal addresses must hold the rounded ceiling and the address space end.
  localparam int AW = ((ADDRESS_BITS > CEIL_W) ? ADDRESS_BITS : CEIL_W) + 1;

  logic [AW-1:0] floor_up;
  logic [AW-1:0] ceil_up;
  cmd_t          cmd;
  status_t       status;

  assign pready = 1'b1;

  brbs_regs #(
    .AW         (AW),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .floor_up (floor_up),
    .ceil_up  (ceil_up)
  );

  brbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .region_valid (region_valid),
    .region_ready (region_ready),
    .block_valid  (block_valid),
    .block_ready  (block_ready),
    .status       (status),
    .cmd          (cmd)
  );

  brbs_dp #(
    .AW           (AW),
    .MAX_ORDER    (MAX_ORDER),
    .ADDRESS_BITS (ADDRESS_BITS),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .region_base   (region_base),
    .region_length (region_length),
    .region_usable (region_usable),
    .last_entry    (last_entry),
    .floor_up      (floor_up),
    .ceil_up       (ceil_up),
    .block_address (block_address),
    .block_order   (block_order),
    .last_block    (last_block)
  );

endmodule

[design/brbs_regs.sv]
// Configuration register file with an APB-style write and read port.
module brbs_regs
  import brbs_pkg::*;
#(
  parameter int AW         = 35,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic [AW-1:0]         floor_up,
  output logic [AW-1:0]         ceil_up
);

  localparam logic [AW-1:0] PM = AW'((64'd1 << PAGE_SHIFT) - 64'd1);

  logic [FIELD_W-1:0] floor_reg;
  logic [CEIL_W-1:0]  ceil_reg;
  logic               wr;
  reg_idx_t           idx;

  assign wr  = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[REG_SEL_BIT]);

  // The page-rounded copies are kept next to the raw values so that the
  // datapath never adds on the register outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_reg <= '0;
      ceil_reg  <= CEIL_RESET;
      floor_up  <= '0;
      ceil_up   <= AW'(CEIL_RESET);
    end else if (wr) begin
      unique case (idx)
        REG_FLOOR: begin
          floor_reg <= pwdata[FIELD_W-1:0];
          floor_up  <= (AW'(pwdata[FIELD_W-1:0]) + PM) & ~PM;
        end
        REG_CEILING: begin
          ceil_reg <= pwdata[CEIL_W-1:0];
          ceil_up  <= (AW'(pwdata[CEIL_W-1:0]) + PM) & ~PM;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FLOOR:   prdata = {{(APB_DATA_W-FIELD_W){1'b0}}, floor_reg};
      REG_CEILING: prdata = {{(APB_DATA_W-CEIL_W){1'b0}}, ceil_reg};
      default:     prdata = '0;
    endcase
  end

endmodule

[design/brbs_ctrl.sv]
// Controller state machine: sequences the setup steps and block emission.
module brbs_ctrl
  import brbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    region_valid,
  output logic    region_ready,
  output logic    block_valid,
  input  logic    block_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALIGN = 5'b00010,
    S_CLIP  = 5'b00100,
    S_SPAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign region_ready = (state == S_IDLE);

  always_comb begin
    cmd.load  = (state == S_IDLE) && region_valid;
    cmd.align = (state == S_ALIGN);
    cmd.clip  = (state == S_CLIP);
    cmd.span  = (state == S_SPAN);
    // A block is loaded when the output register is empty or being emptied.
    cmd.emit  = (state == S_EMIT) && (!block_valid || block_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (region_valid) state_next = S_ALIGN;
      S_ALIGN: state_next = status.go ? S_CLIP : S_IDLE;
      S_CLIP:  state_next = S_SPAN;
      S_SPAN:  state_next = status.nonempty ? S_EMIT : S_IDLE;
      S_EMIT:  if (cmd.emit && status.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        block_valid <= 1'b1;
      end else if (block_ready) begin
        block_valid <= 1'b0;
      end
    end
  end

endmodule

[design/brbs_dp.sv]
// Datapath: region rounding and clipping, block order selection, output register.
module brbs_dp
  import brbs_pkg::*;
#(
  parameter int AW           = 35,
  parameter int MAX_ORDER    = 18,
  parameter int ADDRESS_BITS = 32,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [FIELD_W-1:0] region_base,
  input  logic [FIELD_W-1:0] region_length,
  input  logic               region_usable,
  input  logic               last_entry,
  input  logic [AW-1:0]      floor_up,
  input  logic [AW-1:0]      ceil_up,
  output logic [FIELD_W-1:0] block_address,
  output logic [ORDER_W-1:0] block_order,
  output logic               last_block
);

  localparam logic [AW-1:0] PM    = AW'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [AW-1:0] SPACE = AW'(64'd1 << ADDRESS_BITS);

  logic [FIELD_W-1:0] base_r;
  logic               usable_r;
  logic               last_r;
  logic               past_ceiling;
  logic [AW-1:0]      start;
  logic [AW-1:0]      limit;
  logic [AW-1:0]      len;
  logic [COUNT_W-1:0] count;

  logic [AW-1:0]      skip;
  logic               stop;
  logic [AW-1:0]      sum;
  logic [AW-1:0]      clipped;
  logic [ORDER_W-1:0] order;
  logic [AW-1:0]      blk;

  assign skip = AW'(base_r) & PM;
  assign stop = past_ceiling | (AW'(base_r) >= ceil_up);
  assign sum  = start + len;

  always_comb begin
    clipped = sum;
    if (clipped > ceil_up) clipped = ceil_up;
    if (clipped > SPACE) clipped = SPACE;
  end

  // Alignment and size conditions are monotone in the order, so the highest
  // order that meets both is the block order. Address zero passes every step.
  always_comb begin
    order = '0;
    for (int k = 1; k <= MAX_ORDER; k++) begin
      if (((start & ~({AW{1'b1}} << (PAGE_SHIFT + k))) == '0) &&
          ((len >> (PAGE_SHIFT + k)) != '0)) begin
        order = ORDER_W'(k);
      end
    end
  end

  assign blk = AW'(1) << (PAGE_SHIFT + int'(order));

  always_comb begin
    status.go       = !stop && usable_r && (len >= skip);
    status.nonempty = start < limit;
    status.last     = (len == blk) || (count == COUNT_W'(RESULT_LIMIT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      past_ceiling <= 1'b0;
    end else if (cmd.align) begin
      past_ceiling <= last_r ? 1'b0 : stop;
    end
  end

  // The len register holds the input length, then the trimmed length, then
  // the remaining span while blocks are emitted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r   <= region_base;
      len      <= AW'(region_length);
      usable_r <= region_usable;
      last_r   <= last_entry;
      count    <= '0;
    end else if (cmd.align) begin
      start <= (AW'(base_r) + PM) & ~PM;
      len   <= (len - skip) & ~PM;
    end else if (cmd.clip) begin
      start <= (start < floor_up) ? floor_up : start;
      limit <= clipped;
    end else if (cmd.span) begin
      len <= limit - start;
    end else if (cmd.emit) begin
      block_address <= start[FIELD_W-1:0];
      block_order   <= order;
      last_block    <= status.last;
      start         <= start + blk;
      len           <= len - blk;
      count         <= count + COUNT_W'(1);
    end
  end

endmodule

[design/brbs_checker.sv]
// Port-level checker for the buddy region block splitter, with its bind.
module brbs_checker
  import brbs_pkg::*;
#(
  parameter int MAX_ORDER  = 18,
  parameter int PAGE_SHIFT = 12
) (
  input logic               clk,
  input logic               rst,
  input logic               region_valid,
  input logic               region_ready,
  input logic               block_valid,
  input logic               block_ready,
  input logic [FIELD_W-1:0] block_address,
  input logic [ORDER_W-1:0] block_order,
  input logic               last_block
);

  // Every entry needs setup cycles, so ready drops right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    region_valid && region_ready |=> !region_ready)
    else $error("region_ready stayed high after an accepted entry");

  a_order_range: assert property (@(posedge clk) disable iff (rst)
    block_valid |-> (int'(block_order) <= MAX_ORDER))
    else $error("block order above the maximum");

  // A block must start on a multiple of its own size.
  a_block_aligned: assert property (@(posedge clk) disable iff (rst)
    block_valid |->
      ((((64'd1 << (PAGE_SHIFT + int'(block_order))) - 64'd1) &
        {32'd0, block_address}) == 64'd0))
    else $error("block address not aligned to its order");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    block_valid && !block_ready |=>
      block_valid && $stable(block_address) && $stable(block_order) &&
      $stable(last_block))
    else $error("stalled block word changed");

endmodule

bind buddy_region_block_splitter_unit brbs_checker #(
  .MAX_ORDER  (MAX_ORDER),
  .PAGE_SHIFT (PAGE_SHIFT)
) u_brbs_checker (
  .clk           (clk),
  .rst           (rst),
  .region_valid  (region_valid),
  .region_ready  (region_ready),
  .block_valid   (block_valid),
  .block_ready   (block_ready),
  .block_address (block_address),
  .block_order   (block_order),
  .last_block    (last_block)
);

[bench/tb.sv]
// Self-checking testbench for the buddy region block splitter unit.
module tb;
  import brbs_pkg::*;

  localparam int PAGE           = 12;
  localparam int TOP_ORDER      = 18;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [63:0] SPACE_END = 64'h1_0000_0000;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] length;
    logic               usable;
    logic               last;
  } entry_t;

  typedef struct packed {
    logic [FIELD_W-1:0] addr;
    logic [ORDER_W-1:0] order;
    logic               last;
  } block_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  region_valid = 1'b0;
  logic                  region_ready;
  logic [FIELD_W-1:0]    region_base = '0;
  logic [FIELD_W-1:0]    region_length = '0;
  logic                  region_usable = 1'b0;
  logic                  last_entry = 1'b0;
  logic                  block_valid;
  logic                  block_ready = 1'b0;
  logic [FIELD_W-1:0]    block_address;
  logic [ORDER_W-1:0]    block_order;
  logic                  last_block;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  entry_t pending_entries[$];
  block_t expected_blocks[$];
  entry_t next_entry;
  entry_t seen_entry;

  int unsigned sent_count = 0;
  int unsigned taken_count = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned ready_gap = 0;
  int unsigned ready_calm = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int          errors = 0;
  int          idle_cycles = 0;

  // Predictor copies of the registers and the past-ceiling flag.
  logic [FIELD_W-1:0] floor_copy = '0;
  logic [CEIL_W-1:0]  ceil_copy = CEIL_RESET;
  logic               beyond_ceiling = 1'b0;

  buddy_region_block_splitter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .region_valid (region_valid),
    .region_ready (region_ready),
    .region_base  (region_base),
    .region_length(region_length),
    .region_usable(region_usable),
    .last_entry   (last_entry),
    .block_valid  (block_valid),
    .block_ready  (block_ready),
    .block_address(block_address),
    .block_order  (block_order),
    .last_block   (last_block),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] round_to_page(logic [63:0] v);
    return (v + 64'hFFF) & ~64'hFFF;
  endfunction

  // Largest order allowed by both the alignment of addr and the span left.
  function automatic int unsigned fit_order(logic [63:0] addr, logic [63:0] span);
    int unsigned oa;
    int unsigned os;
    oa = 0;
    os = 0;
    while (oa < TOP_ORDER && addr[PAGE+oa] == 1'b0) oa++;
    while (os < TOP_ORDER && (span >> (PAGE + os + 1)) != 0) os++;
    return (oa < os) ? oa : os;
  endfunction

  function automatic void split_region(entry_t e);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] start;
    logic [63:0] stop;
    logic [63:0] skip;
    logic [63:0] len;
    logic [63:0] next_start;
    int unsigned o;
    int unsigned n;
    block_t b;
    lo = round_to_page({32'b0, floor_copy});
    hi = round_to_page({31'b0, ceil_copy});
    // The ceiling test comes before the usable test.
    if (!beyond_ceiling && {32'b0, e.base} >= hi) beyond_ceiling = 1'b1;
    if (!beyond_ceiling && e.usable) begin
      skip = {52'b0, e.base[PAGE-1:0]};
      len = {32'b0, e.length};
      if (len >= skip) begin
        len = (len - skip) & ~64'hFFF;
        start = round_to_page({32'b0, e.base});
        stop = start + len;
        if (start < lo) start = lo;
        if (stop > hi) stop = hi;
        if (stop > SPACE_END) stop = SPACE_END;
        n = 0;
        while (start < stop && n < RESULT_LIMIT) begin
          o = fit_order(start, stop - start);
          next_start = start + (64'd1 << (PAGE + o));
          b.addr = start[FIELD_W-1:0];
          b.order = o[ORDER_W-1:0];
          b.last = (next_start >= stop) || (n + 1 == RESULT_LIMIT);
          expected_blocks.push_back(b);
          start = next_start;
          n++;
        end
      end
    end
    if (e.last) beyond_ceiling = 1'b0;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_block();
    block_t want;
    if (expected_blocks.size() == 0) begin
      report_mismatch($sformatf("unexpected block at %h order %0d", block_address, block_order));
    end else begin
      want = expected_blocks.pop_front();
      if (block_address !== want.addr)
        report_mismatch($sformatf("block_address %h, expected %h", block_address, want.addr));
      if (block_order !== want.order)
        report_mismatch($sformatf("block_order %0d at %h, expected %0d",
                                  block_order, want.addr, want.order));
      if (last_block !== want.last)
        report_mismatch($sformatf("last_block %b at %h, expected %b",
                                  last_block, want.addr, want.last));
    end
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned random_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Monitor: register writes, accepted map entries and accepted blocks.
  always @(posedge clk) begin
    if (rst) begin
      floor_copy = '0;
      ceil_copy = CEIL_RESET;
      beyond_ceiling = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[REG_SEL_BIT]) == REG_FLOOR) floor_copy = pwdata[FIELD_W-1:0];
        else ceil_copy = pwdata[CEIL_W-1:0];
      end
      if (region_valid && region_ready) begin
        seen_entry.base = region_base;
        seen_entry.length = region_length;
        seen_entry.usable = region_usable;
        seen_entry.last = last_entry;
        split_region(seen_entry);
        taken_count++;
      end
      if (block_valid && block_ready) check_block();
    end
  end

  always @(posedge clk) begin
    if (rst || (region_valid && region_ready) || (block_valid && block_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Entry driver: a word stays on the bus until it has been taken.
  always @(negedge clk) begin
    if (!region_valid || taken_count == sent_count) begin
      if (send_gap > 0) begin
        region_valid <= 1'b0;
        send_gap--;
      end else if (pending_entries.size() > 0) begin
        next_entry = pending_entries.pop_front();
        region_base <= next_entry.base;
        region_length <= next_entry.length;
        region_usable <= next_entry.usable;
        last_entry <= next_entry.last;
        region_valid <= 1'b1;
        sent_count++;
        send_gap = random_gap(send_calm);
      end else begin
        region_valid <= 1'b0;
      end
    end
  end

  // Block receiver; one long hold-off lets the unit back up into its input.
  always @(negedge clk) begin
    if (!hold_done && taken_count >= 30) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      block_ready <= 1'b0;
      hold_left--;
    end else if (ready_gap > 0) begin
      block_ready <= 1'b0;
      ready_gap--;
    end else begin
      block_ready <= 1'b1;
      ready_gap = random_gap(ready_calm);
    end
  end

  task automatic write_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    logic [APB_ADDR_W-1:0] a;
    a = '0;
    a[REG_SEL_BIT] = idx;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_entry(logic [31:0] base, logic [31:0] length, logic usable, logic last);
    entry_t e;
    e.base = base;
    e.length = length;
    e.usable = usable;
    e.last = last;
    pending_entries.push_back(e);
  endtask

  // One memory map: mostly ascending entries near the floor, some noise.
  task automatic queue_map(logic [FIELD_W-1:0] near, inout int made);
    int          n;
    logic [63:0] cursor;
    logic [63:0] offset;
    entry_t      e;
    n = $urandom_range(1, 8);
    cursor = {32'b0, near};
    offset = $urandom_range(0, 32'h20000);
    if ($urandom_range(0, 3) == 0) cursor = {32'b0, $urandom};
    else cursor = (cursor > offset) ? cursor - offset : 64'd0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        e.base = cursor[31:0];
        if ($urandom_range(0, 3) == 0) e.base = e.base + $urandom_range(0, 32'hFFF);
        case ($urandom_range(0, 3))
          0: e.length = $urandom_range(0, 32'h8000);
          1: e.length = $urandom_range(0, 32'h0100_0000);
          2: e.length = $urandom_range(0, 32'h4000_0000);
          default: e.length = $urandom;
        endcase
        e.usable = ($urandom_range(0, 6) != 0);
        e.last = (i == n - 1);
      end else begin
        e.base = $urandom;
        e.length = $urandom;
        e.usable = $urandom_range(0, 1);
        e.last = (i == n - 1) || ($urandom_range(0, 7) == 0);
      end
      cursor = {32'b0, e.base} + {32'b0, e.length} + $urandom_range(0, 32'h10000);
      if (cursor >= SPACE_END) cursor = {32'b0, $urandom};
      pending_entries.push_back(e);
      if (e.usable) made++;
    end
  endtask

  // Empty entries keep the unit busy after the last block.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_entries.size() != 0 || taken_count != sent_count ||
           expected_blocks.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [63:0] floor_val;
    logic [63:0] ceil_val;
    int          quota;
    int          made;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_register(REG_FLOOR, 64'd0);
    write_register(REG_CEILING, CEIL_RESET);
    add_entry(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);  // whole space from address zero
    add_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);  // rounds past the address space
    add_entry(32'hFFFF_F000, 32'hFFFF_FFFF, 1'b1, 1'b0);  // clipped at the address space
    add_entry(32'h0000_1000, 32'hFFFF_E000, 1'b1, 1'b0);  // longest block run
    add_entry(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
    add_entry(32'h0000_1800, 32'h0000_0100, 1'b1, 1'b0);  // shorter than the rounding skip
    add_entry(32'h0000_1FFF, 32'h0000_1000, 1'b1, 1'b0);
    add_entry(32'h0000_1001, 32'h0000_2FFF, 1'b1, 1'b0);
    add_entry(32'h4000_0000, 32'h4000_0000, 1'b0, 1'b1);
    add_entry(32'h1234_5000, 32'h00AB_C000, 1'b1, 1'b1);
    wait_drained();

    write_register(REG_FLOOR, 64'h0001_0001);
    write_register(REG_CEILING, 64'h8000_0800);
    add_entry(32'h0000_0000, 32'h0002_0000, 1'b1, 1'b0);  // clipped at the floor
    add_entry(32'h7FFF_0000, 32'h0010_0000, 1'b1, 1'b0);  // clipped at the ceiling
    add_entry(32'h9000_0000, 32'h0000_1000, 1'b0, 1'b0);  // stops the map
    add_entry(32'h0000_1000, 32'h0001_0000, 1'b1, 1'b0);
    add_entry(32'h0000_2000, 32'h0001_0000, 1'b1, 1'b1);
    add_entry(32'h0000_3000, 32'h0001_0000, 1'b1, 1'b0);
    add_entry(32'h8000_1000, 32'h0000_1000, 1'b1, 1'b1);  // stops and ends in one entry
    add_entry(32'h0000_4000, 32'h0000_1000, 1'b1, 1'b0);
    add_entry(32'h8000_0FFF, 32'h0000_0010, 1'b1, 1'b1);
    add_entry(32'h0001_0000, 32'h0000_3000, 1'b1, 1'b0);
    add_entry(32'h0000_0000, 32'h0001_0000, 1'b1, 1'b1);
    wait_drained();

    for (int k = 0; k < 9; k++) begin
      case (k)
        0: begin
          floor_val = 64'd0;
          ceil_val = CEIL_RESET;
          quota = 50;
        end
        1: begin
          floor_val = 64'hFFFF_FFFF;
          ceil_val = CEIL_RESET;
          quota = 6;
        end
        2: begin
          floor_val = 64'd0;
          ceil_val = 64'd0;
          quota = 6;
        end
        default: begin
          floor_val = {32'b0, $urandom};
          if ($urandom_range(0, 3) == 0)
            ceil_val = {32'b0, $urandom} + $urandom_range(0, 1);
          else
            ceil_val = floor_val + $urandom_range(0, 32'h2000_0000);
          if (ceil_val > CEIL_RESET) ceil_val = CEIL_RESET;
          quota = 26;
        end
      endcase
      write_register(REG_FLOOR, floor_val);
      write_register(REG_CEILING, ceil_val);
      made = 0;
      while (made < quota) queue_map(floor_val[FIELD_W-1:0], made);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
